FILE: rtl/tmqb_pkg.sv
`timescale 1ns / 1ps
package tmqb_pkg;

   // field widths fixed by the interface
   localparam int STAMP_W = 16;
   localparam int LEN_W   = 7;
   localparam int BYTE_W  = 8;
   localparam int STAT_W  = 3;
   localparam int QID_W   = 4;
   localparam int BUDG_W  = 24;
   localparam int USED_W  = 25;

   // request codes
   localparam logic [1:0] REQ_PUT   = 2'd0;
   localparam logic [1:0] REQ_GET   = 2'd1;
   localparam logic [1:0] REQ_QUERY = 2'd2;
   localparam logic [1:0] REQ_RSVD  = 2'd3;

   // result status codes
   localparam logic [STAT_W-1:0] ST_PUT_OK  = 3'd0;
   localparam logic [STAT_W-1:0] ST_REFUSED = 3'd1;
   localparam logic [STAT_W-1:0] ST_BAD_Q   = 3'd2;
   localparam logic [STAT_W-1:0] ST_BYTE    = 3'd3;
   localparam logic [STAT_W-1:0] ST_NONE    = 3'd4;
   localparam logic [STAT_W-1:0] ST_DROPPED = 3'd5;
   localparam logic [STAT_W-1:0] ST_QUERY   = 3'd6;

   // register indexes
   localparam logic [1:0] REG_BUDGET_BIG   = 2'd0;
   localparam logic [1:0] REG_BUDGET_SMALL = 2'd1;
   localparam logic [1:0] REG_BIG_COUNT    = 2'd2;
   localparam logic [1:0] REG_OVERHEAD     = 2'd3;

   // reset values of the registers
   localparam logic [BUDG_W-1:0] BUDGET_BIG_RST   = 24'(1024 * 1024);
   localparam logic [BUDG_W-1:0] BUDGET_SMALL_RST = 24'(512 * 1024);
   localparam logic [4:0]        BIG_COUNT_RST    = 5'd4;
   localparam logic [7:0]        OVERHEAD_RST     = 8'd24;

   typedef struct packed {
      logic [STAMP_W-1:0] stamp;
      logic [LEN_W-1:0]   len;
   } meta_type;

endpackage

FILE: rtl/tmqb_ram.sv
`timescale 1ns / 1ps
module tmqb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: rtl/tagged_multi_queue_buffer_core.sv
`timescale 1ns / 1ps
// a put byte that is not last leaves the sequencer idle; a commit walks the order list, copies
// the payload from staging and writes the slot and order entries; a get walks to the match,
// closes the gap in the order list and reads the payload out; requests are served one at a
// time, set by the serial walk over the order list and the one-byte-a-cycle payload memory ports
// reset: synchronous active-high, clears counts, byte charges, staging count; registers to defaults
module tagged_multi_queue_buffer_core #(
   parameter int NUM_QUEUES        = 8,
   parameter int SLOTS_PER_QUEUE   = 16,
   parameter int MAX_MESSAGE_BYTES = 64
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [3:0]  req_queue_id,
   input  logic [15:0] req_stamp,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic [6:0]  req_max_length,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_data_out,
   output logic [15:0] rsp_stamp_out,
   output logic [6:0]  rsp_length_out,
   output logic        rsp_last,
   output logic        rsp_is_empty,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int TOTAL  = NUM_QUEUES * SLOTS_PER_QUEUE;
   localparam int QW     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int SW     = (SLOTS_PER_QUEUE > 1) ? $clog2(SLOTS_PER_QUEUE) : 1;
   localparam int CW     = $clog2(SLOTS_PER_QUEUE + 1);
   localparam int BIW    = $clog2(MAX_MESSAGE_BYTES + 1);
   localparam int IW     = (BIW > CW) ? BIW : CW;
   // byte memory: message payloads, then the staging area
   localparam int BDEPTH = TOTAL * MAX_MESSAGE_BYTES + MAX_MESSAGE_BYTES;
   localparam int BAW    = $clog2(BDEPTH);
   // slot memory: stamp and length per slot, then the order lists
   localparam int SDEPTH = 2 * TOTAL;
   localparam int SAW    = $clog2(SDEPTH);
   localparam int MW     = tmqb_pkg::STAMP_W + tmqb_pkg::LEN_W;
   localparam int NEED_W = tmqb_pkg::USED_W + 1;

   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_PCHK  = 4'd1;
   localparam logic [3:0] S_OSCAN = 4'd2;
   localparam logic [3:0] S_OWAIT = 4'd3;
   localparam logic [3:0] S_MCHK  = 4'd4;
   localparam logic [3:0] S_PSLOT = 4'd5;
   localparam logic [3:0] S_CPRD  = 4'd6;
   localparam logic [3:0] S_CPWR  = 4'd7;
   localparam logic [3:0] S_META  = 4'd8;
   localparam logic [3:0] S_ORDW  = 4'd9;
   localparam logic [3:0] S_SHIFT = 4'd10;
   localparam logic [3:0] S_SHWR  = 4'd11;
   localparam logic [3:0] S_GFIN  = 4'd12;
   localparam logic [3:0] S_PRD   = 4'd13;
   localparam logic [3:0] S_PSEND = 4'd14;
   localparam logic [3:0] S_REPLY = 4'd15;

   // control and request registers
   logic [3:0]                  state_ff, state_in;
   logic [1:0]                  op_ff, op_in;
   logic [3:0]                  q_ff, q_in;
   logic [15:0]                 stamp_ff, stamp_in;
   logic [6:0]                  maxlen_ff, maxlen_in;
   logic [IW-1:0]               idx_ff, idx_in;
   logic [CW-1:0]               cnt_ff, cnt_in;
   logic [SLOTS_PER_QUEUE-1:0]  used_ff, used_in;
   logic [SW-1:0]               slot_ff, slot_in;
   logic [6:0]                  len_ff, len_in;
   logic [NEED_W-1:0]           need_ff, need_in;
   logic [15:0]                 mstamp_ff, mstamp_in;
   logic [2:0]                  res_status_ff, res_status_in;
   logic                        res_empty_ff, res_empty_in;
   logic [BIW-1:0]              stg_cnt_ff, stg_cnt_in;

   // per-queue state
   logic [CW-1:0]               entry_count_ff [NUM_QUEUES];
   logic [CW-1:0]               entry_count_in [NUM_QUEUES];
   logic [tmqb_pkg::USED_W-1:0] bytes_used_ff  [NUM_QUEUES];
   logic [tmqb_pkg::USED_W-1:0] bytes_used_in  [NUM_QUEUES];

   // configuration
   logic [23:0] budget_big_ff, budget_big_in;
   logic [23:0] budget_small_ff, budget_small_in;
   logic [4:0]  big_count_ff, big_count_in;
   logic [7:0]  overhead_ff, overhead_in;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic [7:0]  rsp_data_ff, rsp_data_in;
   logic [15:0] rsp_stamp_ff, rsp_stamp_in;
   logic [6:0]  rsp_len_ff, rsp_len_in;
   logic        rsp_last_ff, rsp_last_in;
   logic        rsp_empty_ff, rsp_empty_in;

   // memory ports
   logic           bm_we, bm_re;
   logic [BAW-1:0] bm_waddr, bm_raddr;
   logic [7:0]     bm_wdata, bm_rdata;
   logic           sm_we, sm_re;
   logic [SAW-1:0] sm_waddr, sm_raddr;
   logic [MW-1:0]  sm_wdata, sm_rdata;

   // helpers
   logic                   accept, out_free, cfg_wr, req_q_ok, match;
   logic [QW-1:0]          qi, rqi;
   logic [SAW-1:0]         slot_base;
   logic [BAW-1:0]         slot_byte_base;
   logic [SW-1:0]          free_slot, ord_rd;
   tmqb_pkg::meta_type     meta_rd;
   logic [23:0]            budget;
   logic [NEED_W-1:0]      need;
   logic [8:0]             charge;
   logic [IW-1:0]          idx_nx;

   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign cfg_wr    = psel && penable && pwrite;
   assign req_q_ok  = {1'b0, req_queue_id} < 5'(NUM_QUEUES);
   assign qi        = q_ff[QW-1:0];
   assign rqi       = req_queue_id[QW-1:0];
   assign slot_base = SAW'(q_ff) * SAW'(SLOTS_PER_QUEUE);
   assign slot_byte_base = (BAW'(slot_base) + BAW'(slot_ff)) * BAW'(MAX_MESSAGE_BYTES);
   assign meta_rd   = tmqb_pkg::meta_type'(sm_rdata);
   assign ord_rd    = sm_rdata[SW-1:0];
   assign match     = (stamp_ff == 16'd0) || (meta_rd.stamp == stamp_ff);
   assign idx_nx    = idx_ff + IW'(1);
   assign budget    = ({1'b0, q_ff} < big_count_ff) ? budget_big_ff : budget_small_ff;
   assign need      = NEED_W'(bytes_used_ff[qi]) + NEED_W'(len_ff) + NEED_W'(overhead_ff);
   assign charge    = 9'(len_ff) + 9'(overhead_ff);

   // lowest free slot, top slot when none is free below it
   always_comb begin
      free_slot = SW'(SLOTS_PER_QUEUE - 1);
      for (int i = SLOTS_PER_QUEUE - 2; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_slot = SW'(i);
         end
      end
   end

   // configuration write and read back
   always_comb begin
      budget_big_in   = budget_big_ff;
      budget_small_in = budget_small_ff;
      big_count_in    = big_count_ff;
      overhead_in     = overhead_ff;
      if (cfg_wr) begin
         unique case (paddr[3:2])
            tmqb_pkg::REG_BUDGET_BIG:   budget_big_in   = pwdata[23:0];
            tmqb_pkg::REG_BUDGET_SMALL: budget_small_in = pwdata[23:0];
            tmqb_pkg::REG_BIG_COUNT:    big_count_in    = pwdata[4:0];
            tmqb_pkg::REG_OVERHEAD:     overhead_in     = pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         tmqb_pkg::REG_BUDGET_BIG:   prdata = {8'd0, budget_big_ff};
         tmqb_pkg::REG_BUDGET_SMALL: prdata = {8'd0, budget_small_ff};
         tmqb_pkg::REG_BIG_COUNT:    prdata = {27'd0, big_count_ff};
         tmqb_pkg::REG_OVERHEAD:     prdata = {24'd0, overhead_ff};
         default:                    prdata = 32'd0;
      endcase
   end

   assign pready = 1'b1;

   // main sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      q_in          = q_ff;
      stamp_in      = stamp_ff;
      maxlen_in     = maxlen_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      used_in       = used_ff;
      slot_in       = slot_ff;
      len_in        = len_ff;
      need_in       = need_ff;
      mstamp_in     = mstamp_ff;
      res_status_in = res_status_ff;
      res_empty_in  = res_empty_ff;
      stg_cnt_in    = stg_cnt_ff;
      entry_count_in = entry_count_ff;
      bytes_used_in  = bytes_used_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_stamp_in  = rsp_stamp_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_empty_in  = rsp_empty_ff;

      bm_we = 1'b0; bm_waddr = '0; bm_wdata = '0;
      bm_re = 1'b0; bm_raddr = '0;
      sm_we = 1'b0; sm_waddr = '0; sm_wdata = '0;
      sm_re = 1'b0; sm_raddr = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in         = req_type;
               q_in          = req_queue_id;
               stamp_in      = req_stamp;
               maxlen_in     = req_max_length;
               idx_in        = '0;
               used_in       = '0;
               res_empty_in  = 1'b0;
               cnt_in        = entry_count_ff[rqi];
               unique case (req_type)
                  tmqb_pkg::REQ_PUT: begin
                     // append to staging, bytes past the limit are lost
                     if (32'(stg_cnt_ff) < MAX_MESSAGE_BYTES) begin
                        bm_we      = 1'b1;
                        bm_waddr   = BAW'(TOTAL * MAX_MESSAGE_BYTES) + BAW'(stg_cnt_ff);
                        bm_wdata   = req_data_byte;
                        stg_cnt_in = stg_cnt_ff + BIW'(1);
                     end
                     if (req_last_byte) begin
                        len_in     = 7'(stg_cnt_in);
                        stg_cnt_in = '0;
                        if (req_q_ok) begin
                           state_in = S_PCHK;
                        end else begin
                           res_status_in = tmqb_pkg::ST_BAD_Q;
                           state_in      = S_REPLY;
                        end
                     end
                  end
                  tmqb_pkg::REQ_GET, tmqb_pkg::REQ_QUERY: begin
                     if (!req_q_ok) begin
                        res_status_in = tmqb_pkg::ST_BAD_Q;
                        res_empty_in  = (req_type == tmqb_pkg::REQ_QUERY);
                        state_in      = S_REPLY;
                     end else if (entry_count_ff[rqi] == '0) begin
                        res_status_in = (req_type == tmqb_pkg::REQ_QUERY) ?
                                        tmqb_pkg::ST_QUERY : tmqb_pkg::ST_NONE;
                        res_empty_in  = (req_type == tmqb_pkg::REQ_QUERY);
                        state_in      = S_REPLY;
                     end else begin
                        state_in = S_OSCAN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_PCHK: begin
            need_in = need;
            if (32'(cnt_ff) >= SLOTS_PER_QUEUE ||
                (budget != 24'd0 && need > NEED_W'(budget))) begin
               res_status_in = tmqb_pkg::ST_REFUSED;
               state_in      = S_REPLY;
            end else if (cnt_ff == '0) begin
               state_in = S_PSLOT;
            end else begin
               state_in = S_OSCAN;
            end
         end
         S_OSCAN: begin
            // fetch order entry idx of the queue
            sm_re    = 1'b1;
            sm_raddr = SAW'(TOTAL) + slot_base + SAW'(idx_ff);
            state_in = S_OWAIT;
         end
         S_OWAIT: begin
            if (op_ff == tmqb_pkg::REQ_PUT) begin
               used_in[ord_rd] = 1'b1;
               idx_in          = idx_nx;
               state_in        = (idx_nx == IW'(cnt_ff)) ? S_PSLOT : S_OSCAN;
            end else begin
               slot_in  = ord_rd;
               sm_re    = 1'b1;
               sm_raddr = slot_base + SAW'(ord_rd);
               state_in = S_MCHK;
            end
         end
         S_MCHK: begin
            if (match) begin
               if (op_ff == tmqb_pkg::REQ_QUERY) begin
                  res_status_in = tmqb_pkg::ST_QUERY;
                  res_empty_in  = 1'b0;
                  state_in      = S_REPLY;
               end else begin
                  len_in    = meta_rd.len;
                  mstamp_in = meta_rd.stamp;
                  state_in  = S_SHIFT;
               end
            end else begin
               idx_in = idx_nx;
               if (idx_nx == IW'(cnt_ff)) begin
                  res_status_in = (op_ff == tmqb_pkg::REQ_QUERY) ?
                                  tmqb_pkg::ST_QUERY : tmqb_pkg::ST_NONE;
                  res_empty_in  = (op_ff == tmqb_pkg::REQ_QUERY);
                  state_in      = S_REPLY;
               end else begin
                  state_in = S_OSCAN;
               end
            end
         end
         S_PSLOT: begin
            slot_in  = free_slot;
            idx_in   = '0;
            state_in = S_CPRD;
         end
         S_CPRD: begin
            bm_re    = 1'b1;
            bm_raddr = BAW'(TOTAL * MAX_MESSAGE_BYTES) + BAW'(idx_ff);
            state_in = S_CPWR;
         end
         S_CPWR: begin
            bm_we    = 1'b1;
            bm_waddr = slot_byte_base + BAW'(idx_ff);
            bm_wdata = bm_rdata;
            idx_in   = idx_nx;
            state_in = (idx_nx == IW'(len_ff)) ? S_META : S_CPRD;
         end
         S_META: begin
            sm_we    = 1'b1;
            sm_waddr = slot_base + SAW'(slot_ff);
            sm_wdata = {stamp_ff, len_ff};
            state_in = S_ORDW;
         end
         S_ORDW: begin
            sm_we              = 1'b1;
            sm_waddr           = SAW'(TOTAL) + slot_base + SAW'(cnt_ff);
            sm_wdata           = MW'(slot_ff);
            entry_count_in[qi] = cnt_ff + CW'(1);
            bytes_used_in[qi]  = need_ff[tmqb_pkg::USED_W-1:0];
            res_status_in      = tmqb_pkg::ST_PUT_OK;
            state_in           = S_REPLY;
         end
         S_SHIFT: begin
            // close the gap left in the order list
            if (32'(idx_nx) < 32'(cnt_ff)) begin
               sm_re    = 1'b1;
               sm_raddr = SAW'(TOTAL) + slot_base + SAW'(idx_nx);
               state_in = S_SHWR;
            end else begin
               state_in = S_GFIN;
            end
         end
         S_SHWR: begin
            sm_we    = 1'b1;
            sm_waddr = SAW'(TOTAL) + slot_base + SAW'(idx_ff);
            sm_wdata = sm_rdata;
            idx_in   = idx_nx;
            state_in = S_SHIFT;
         end
         S_GFIN: begin
            entry_count_in[qi] = cnt_ff - CW'(1);
            bytes_used_in[qi]  = (bytes_used_ff[qi] > tmqb_pkg::USED_W'(charge)) ?
                                 bytes_used_ff[qi] - tmqb_pkg::USED_W'(charge) : '0;
            idx_in             = '0;
            if (len_ff > maxlen_ff) begin
               res_status_in = tmqb_pkg::ST_DROPPED;
               state_in      = S_REPLY;
            end else begin
               state_in = S_PRD;
            end
         end
         S_PRD: begin
            bm_re    = 1'b1;
            bm_raddr = slot_byte_base + BAW'(idx_ff);
            state_in = S_PSEND;
         end
         S_PSEND: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = tmqb_pkg::ST_BYTE;
               rsp_data_in   = bm_rdata;
               rsp_stamp_in  = mstamp_ff;
               rsp_len_in    = len_ff;
               rsp_last_in   = (idx_nx == IW'(len_ff));
               rsp_empty_in  = 1'b0;
               idx_in        = idx_nx;
               state_in      = (idx_nx == IW'(len_ff)) ? S_IDLE : S_PRD;
            end
         end
         S_REPLY: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_data_in   = 8'd0;
               rsp_stamp_in  = (res_status_ff == tmqb_pkg::ST_DROPPED) ? mstamp_ff : 16'd0;
               rsp_len_in    = (res_status_ff == tmqb_pkg::ST_DROPPED) ? len_ff : 7'd0;
               rsp_last_in   = 1'b1;
               rsp_empty_in  = res_empty_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         stg_cnt_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
         budget_big_ff   <= tmqb_pkg::BUDGET_BIG_RST;
         budget_small_ff <= tmqb_pkg::BUDGET_SMALL_RST;
         big_count_ff    <= tmqb_pkg::BIG_COUNT_RST;
         overhead_ff     <= tmqb_pkg::OVERHEAD_RST;
         for (int i = 0; i < NUM_QUEUES; i++) begin
            entry_count_ff[i] <= '0;
            bytes_used_ff[i]  <= '0;
         end
      end else begin
         state_ff        <= state_in;
         stg_cnt_ff      <= stg_cnt_in;
         rsp_valid_ff    <= rsp_valid_in;
         budget_big_ff   <= budget_big_in;
         budget_small_ff <= budget_small_in;
         big_count_ff    <= big_count_in;
         overhead_ff     <= overhead_in;
         entry_count_ff  <= entry_count_in;
         bytes_used_ff   <= bytes_used_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      q_ff          <= q_in;
      stamp_ff      <= stamp_in;
      maxlen_ff     <= maxlen_in;
      idx_ff        <= idx_in;
      cnt_ff        <= cnt_in;
      used_ff       <= used_in;
      slot_ff       <= slot_in;
      len_ff        <= len_in;
      need_ff       <= need_in;
      mstamp_ff     <= mstamp_in;
      res_status_ff <= res_status_in;
      res_empty_ff  <= res_empty_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_stamp_ff  <= rsp_stamp_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   // payload bytes and staging area
   tmqb_ram #(.WIDTH(8), .DEPTH(BDEPTH)) u_byte_ram (
      .clock   (clock),
      .wr_en   (bm_we),
      .wr_addr (bm_waddr),
      .wr_data (bm_wdata),
      .rd_en   (bm_re),
      .rd_addr (bm_raddr),
      .rd_data (bm_rdata)
   );

   // slot stamp and length, and the order lists
   tmqb_ram #(.WIDTH(MW), .DEPTH(SDEPTH)) u_slot_ram (
      .clock   (clock),
      .wr_en   (sm_we),
      .wr_addr (sm_waddr),
      .wr_data (sm_wdata),
      .rd_en   (sm_re),
      .rd_addr (sm_raddr),
      .rd_data (sm_rdata)
   );

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_data_out   = rsp_data_ff;
   assign rsp_stamp_out  = rsp_stamp_ff;
   assign rsp_length_out = rsp_len_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_is_empty   = rsp_empty_ff;

   // staging never passes the message limit
   a_stg_bound: assert property (@(posedge clock) disable iff (reset)
      32'(stg_cnt_ff) <= MAX_MESSAGE_BYTES)
      else $error("staging count beyond limit");

   // a commit only lands in a queue with a free slot
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ORDW) |-> (32'(cnt_ff) < SLOTS_PER_QUEUE))
      else $error("entry count beyond slots");

   // only payload beats may be non-final
   a_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (rsp_status_ff == tmqb_pkg::ST_BYTE))
      else $error("non-final beat without payload status");

   // a commit always leaves through the reply state
   a_commit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ORDW) |=> (state_ff == S_REPLY))
      else $error("commit without reply");

endmodule
